// ===== hw/rtl/aef_pkg.sv =====
// Shared constants, command type and widths for the ADC EMA filter.
package aef_pkg;

  localparam int SampleW  = 12;
  localparam int AlphaW   = 17;
  localparam int Q16W     = 28;
  localparam int MvW      = 16;
  localparam int ScaledW  = 20;   // sample * 220, max 900900
  localparam int QuotW    = 12;   // whole millivolts, max 3300
  localparam int RemW     = 9;    // remainder of divide by 273
  localparam int FracW    = 16;
  localparam int Recip1W  = 21;
  localparam int Recip2W  = 26;
  localparam int InDataW  = 16;
  localparam int OutDataW = 48;

  // 3300/4095 reduces to 220/273
  localparam logic [7:0]          SCALE_MUL    = 8'd220;
  localparam logic [8:0]          DIVISOR      = 9'd273;
  // ceil(2^29/273): exact floor(m/273) for m < 2^20
  localparam logic [Recip1W-1:0]  RECIP1       = 21'd1966561;
  localparam int                  Recip1Shift  = 29;
  // ceil(2^34/273): exact floor(r*65536/273) for r < 273
  localparam logic [Recip2W-1:0]  RECIP2       = 26'd62929924;
  localparam int                  Recip2Shift  = 18;
  localparam logic [AlphaW-1:0]   ALPHA_ONE    = 17'd65536;
  localparam logic [AlphaW-1:0]   ALPHA_RESET  = 17'd16384;
  localparam logic [Q16W-1:0]     Q16_MAX      = 28'd216268800;
  localparam logic [16:0]         ROUND_HALF   = 17'd32768;

  // one-hot step strobes from the sequencer
  typedef struct packed {
    logic load;
    logic scale;
    logic quot;
    logic rem;
    logic frac;
    logic mac;
    logic upd;
    logic out;
  } aef_cmd_t;

endpackage

// ===== hw/rtl/aef_ctrl.sv =====
// Sequencer for the ADC EMA filter: steps the datapath and owns the handshakes.
module aef_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output aef_pkg::aef_cmd_t cmd
);
  import aef_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_QUOT,
    S_REM,
    S_FRAC,
    S_MAC,
    S_UPD,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.scale = (state == S_SCALE);
    cmd.quot  = (state == S_QUOT);
    cmd.rem   = (state == S_REM);
    cmd.frac  = (state == S_FRAC);
    cmd.mac   = (state == S_MAC);
    cmd.upd   = (state == S_UPD);
    cmd.out   = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result load wins over the handoff of the old one
      if (cmd.out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (in_valid) state <= S_SCALE;
        S_SCALE: state <= S_QUOT;
        S_QUOT:  state <= S_REM;
        S_REM:   state <= S_FRAC;
        S_FRAC:  state <= S_MAC;
        S_MAC:   state <= S_UPD;
        S_UPD:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aef_datapath.sv =====
// Datapath for the ADC EMA filter: mV conversion, EMA update, output payload.
module aef_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  aef_pkg::aef_cmd_t           cmd,
  input  logic [aef_pkg::SampleW-1:0] sample_in,
  input  logic                        cfg_we,
  input  logic [aef_pkg::AlphaW-1:0]  cfg_data,
  output logic [aef_pkg::Q16W-1:0]    q16_out,
  output logic [aef_pkg::MvW-1:0]     mv_out
);
  import aef_pkg::*;

  logic [AlphaW-1:0]  alpha;
  logic [SampleW-1:0] sample;
  logic [ScaledW-1:0] scaled;
  logic [QuotW-1:0]   quot;
  logic [RemW-1:0]    rem;
  logic [Q16W-1:0]    x;
  logic [Q16W-1:0]    y;
  logic signed [46:0] prod;

  logic [ScaledW+Recip1W-1:0] prod1;
  logic [ScaledW-1:0]         rem_full;
  logic [RemW+Recip2W-1:0]    prod2;
  logic [AlphaW-1:0]          alpha_eff;
  logic signed [17:0]         alpha_s;
  logic signed [28:0]         diff;
  logic signed [46:0]         prod_next;
  logic signed [46:0]         rounded;
  logic signed [31:0]         y_sum;
  logic [Q16W-1:0]            y_next;
  logic [Q16W:0]              mv_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha <= cfg_data;
    end
  end

  // floor(m/273) by reciprocal, then remainder, then fractional part
  assign prod1    = {{Recip1W{1'b0}}, scaled} * {{ScaledW{1'b0}}, RECIP1};
  assign rem_full = scaled - ScaledW'(quot) * ScaledW'(DIVISOR);
  assign prod2    = {{Recip2W{1'b0}}, rem} * {{RemW{1'b0}}, RECIP2};

  assign alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign alpha_s   = $signed({1'b0, alpha_eff});
  assign diff      = $signed({1'b0, x}) - $signed({1'b0, y});
  assign prod_next = alpha_s * diff;

  assign rounded = prod + $signed({30'd0, ROUND_HALF});
  assign y_sum   = $signed({4'd0, y}) + {rounded[46], rounded[46:16]};

  always_comb begin
    if (y_sum < 0) begin
      y_next = '0;
    end else if (y_sum > $signed({4'd0, {Q16W{1'b1}}})) begin
      y_next = {Q16W{1'b1}};
    end else begin
      y_next = y_sum[Q16W-1:0];
    end
  end

  // y <= 3300 mV, so the int16 clamp never engages: 13 bits fit directly
  assign mv_sum = {1'b0, y} + (Q16W+1)'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      y <= '0;
    end else if (cmd.upd) begin
      y <= y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)  sample <= sample_in;
    if (cmd.scale) scaled <= ScaledW'(sample) * ScaledW'(SCALE_MUL);
    if (cmd.quot)  quot   <= prod1[Recip1Shift+QuotW-1:Recip1Shift];
    if (cmd.rem)   rem    <= rem_full[RemW-1:0];
    if (cmd.frac)  x      <= {quot, prod2[Recip2Shift+FracW-1:Recip2Shift]};
    if (cmd.mac)   prod   <= prod_next;
    if (cmd.out) begin
      q16_out <= y;
      mv_out  <= {3'd0, mv_sum[Q16W:16]};
    end
  end

endmodule

// ===== hw/rtl/adc_ema_filter_top.sv =====
// Top level of the ADC EMA filter: stream ports, sequencer and datapath.
// Each accepted request runs through the seven-step sequencer (scale, reciprocal divide,
//   remainder, fraction, multiply, update, output); the result is valid after the output
//   step, which waits while an earlier result is still held. Requests are taken only in idle.
// The next request is taken while a finished result waits on the output.
// Reset (rst, sync, active high): filter value 0, alpha 16384, no result held.
module adc_ema_filter_top (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [aef_pkg::InDataW-1:0]  s_tdata,   // [11:0] adc_sample
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [aef_pkg::OutDataW-1:0] m_tdata,   // [27:0] filtered_q16, [43:28] filtered_mv
  // alpha register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aef_pkg::AlphaW-1:0]   cfg_data
);
  import aef_pkg::*;

  aef_cmd_t          cmd;
  logic [Q16W-1:0]   q16;
  logic [MvW-1:0]    mv;

  // register writes land at once; that config only changes while idle is up to the user, unchecked by the block
  assign cfg_ready = 1'b1;

  aef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  aef_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample_in (s_tdata[SampleW-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q16_out   (q16),
    .mv_out    (mv)
  );

  // pack result, pad to whole bytes
  assign m_tdata = {{(OutDataW-Q16W-MvW){1'b0}}, mv, q16};

  // sequencer busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready while a request is in flight");

  // output valid only drops when taken and no new load
  a_valid_drop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !cmd.out) |=> !m_tvalid)
    else $error("result repeated after handoff");

  // filter value stays within full scale
  a_q16_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[Q16W-1:0] <= Q16_MAX))
    else $error("filtered value above full scale");

  // no result load while a result is held and not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out |-> (!m_tvalid || m_tready))
    else $error("result overwritten before handoff");

endmodule

// ===== tb/sv/aef_checker.sv =====
// Checker for the ADC EMA filter: watches all channels, predicts each result and compares.
module aef_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [aef_pkg::InDataW-1:0]  s_tdata,   // [11:0] adc_sample
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [aef_pkg::OutDataW-1:0] m_tdata,   // [27:0] filtered_q16, [43:28] filtered_mv
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [aef_pkg::AlphaW-1:0]   cfg_data,
  output int                           mismatches,
  output int                           pending,
  output int                           checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import aef_pkg::*;

  localparam longint MV_FULL_SCALE  = 3300;
  localparam longint ADC_FULL_SCALE = 4095;
  localparam longint Q28_TOP        = (64'd1 << Q16W) - 1;
  localparam longint MV_MAX         = 32767;

  typedef struct packed {
    logic [Q16W-1:0]        q16;
    logic signed [MvW-1:0]  mv;
  } ema_result_t;

  ema_result_t       expected_q[$];
  logic [AlphaW-1:0] alpha_reg;
  logic [Q16W-1:0]   ema_value;
  int                n_bad;
  int                n_checked;

  // one EMA step: convert the count to Q16.16 mV, move y toward it by alpha
  function automatic ema_result_t ema_next(input logic [SampleW-1:0] sample,
                                           input logic [AlphaW-1:0]  alpha,
                                           input logic [Q16W-1:0]    y);
    longint      weight;
    longint      x_q16;
    longint      step;
    longint      ny;
    longint      mv;
    ema_result_t r;
    weight = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
    x_q16  = ((longint'(sample) * MV_FULL_SCALE) << FracW) / ADC_FULL_SCALE;
    // arithmetic shift of a signed value is a floor, so this rounds half up
    step   = (weight * (x_q16 - longint'(y)) + longint'(ROUND_HALF)) >>> FracW;
    ny     = longint'(y) + step;
    if (ny < 0) ny = 0;
    if (ny > Q28_TOP) ny = Q28_TOP;
    mv = (ny + longint'(ROUND_HALF)) >>> FracW;
    if (mv > MV_MAX) mv = MV_MAX;
    r.q16 = ny[Q16W-1:0];
    r.mv  = mv[MvW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ema_result_t want;
    ema_result_t got;
    if (rst) begin
      alpha_reg = ALPHA_RESET;
      ema_value = '0;
      expected_q.delete();
      n_bad     = 0;
      n_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) alpha_reg = cfg_data;
      if (s_tvalid && s_tready) begin
        want      = ema_next(s_tdata[SampleW-1:0], alpha_reg, ema_value);
        ema_value = want.q16;
        expected_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.q16 = m_tdata[Q16W-1:0];
        got.mv  = m_tdata[Q16W +: MvW];
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: filtered_q16 %0d", got.q16);
          n_bad++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got.q16 !== want.q16) begin
            $error("filtered_q16 mismatch: expected %0d, got %0d", want.q16, got.q16);
            n_bad++;
          end
          if (got.mv !== want.mv) begin
            $error("filtered_mv mismatch: expected %0d, got %0d", want.mv, got.mv);
            n_bad++;
          end
        end
      end
    end
    mismatches <= n_bad;
    pending    <= expected_q.size();
    checked    <= n_checked;
  end

endmodule

// ===== tb/sv/tb_adc_ema_filter_top.sv =====
// Testbench top for the ADC EMA filter: stimulus, output stalls and verdict.
module tb_adc_ema_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aef_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 20;
  localparam int PHASE_ITEMS = 85;
  localparam logic [AlphaW-1:0] ALPHA_TOP = '1;  // above range, saturates to 1.0

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;   // [11:0] adc_sample
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;   // [27:0] filtered_q16, [43:28] filtered_mv
  logic                cfg_valid;
  logic                cfg_ready;
  logic [AlphaW-1:0]   cfg_data;

  int mismatches;
  int pending;
  int checked;
  int cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int samples_sent = 0;
  int alpha_writes = 0;

  adc_ema_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  aef_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("** adc_ema_filter_top: FAILED **");
      $finish;
    end
  end

  // output side: stretches of always-ready, coin-flip ready, and long stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // present one sample; valid stays up afterwards so back-to-back requests run
  task automatic send_sample(input logic [SampleW-1:0] sample);
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'(sample);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic idle_input(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and hold off until every predicted result is back
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // alpha is only written with the filter idle
  task automatic write_alpha(input logic [AlphaW-1:0] alpha);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= alpha;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    alpha_writes++;
  endtask

  // mostly full-range counts, with the rails and near-rail values mixed in
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SampleW'($urandom_range(0, 15));
      3:       return SampleW'($urandom_range(4080, 4095));
      default: return SampleW'($urandom_range(0, 4095));
    endcase
  endfunction

  // random phase: bursts of random length, gaps of random length or none
  task automatic random_phase(input logic [AlphaW-1:0] alpha);
    int left;
    int burst;
    write_alpha(alpha);
    left = PHASE_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_sample(pick_sample());
        left--;
      end
      if ($urandom_range(0, 1) != 0) idle_input($urandom_range(1, 15));
    end
  endtask

  initial begin
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset alpha (0.25): rails, alternating bit patterns, near-rail counts
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'd1);
    send_sample(12'd4094);
    idle_input(3);
    send_sample(12'd2048);

    // pass-through: y follows the sample exactly
    write_alpha(ALPHA_ONE);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd1234);

    // alpha zero: y holds whatever the sample is
    write_alpha('0);
    send_sample(12'd4095);
    send_sample(12'd0);

    // above range: saturates to pass-through, all register bits set
    write_alpha(ALPHA_TOP);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd100);

    // smallest nonzero weight: each step moves y by the gap to the sample over 65536, rounded
    write_alpha(17'd1);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd0);

    random_phase(AlphaW'($urandom_range(1, 65535)));
    random_phase(17'd65535);
    random_phase(AlphaW'($urandom_range(65537, 131071)));
    random_phase(AlphaW'($urandom_range(1, 4096)));
    random_phase(AlphaW'($urandom_range(0, 131071)));
    random_phase(ALPHA_RESET);

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d samples across %0d alpha settings (0, 1, full, over range).",
             samples_sent, alpha_writes + 1);
    $display("%0d results checked, %0d mismatches, %0d outstanding.",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("** adc_ema_filter_top: PASSED **");
    end else begin
      $display("** adc_ema_filter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/aef_pkg.sv
hw/rtl/aef_ctrl.sv
hw/rtl/aef_datapath.sv
hw/rtl/adc_ema_filter_top.sv
tb/sv/aef_checker.sv
tb/sv/tb_adc_ema_filter_top.sv
